// ===== rtl/rmea_pkg.sv =====
// Shared types, constants and helper functions for the rotation matrix to
// Euler angle converter. No dependencies; every other file but rmea_if uses it.
package rmea_pkg;

  localparam int CW = 34;  // CORDIC datapath width (x, y and angle in Q30 rad)
  localparam int SW = 30;  // square root datapath width
  localparam int SQRT_CELLS = 15;
  localparam int TAB_LEN = 30;

  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [16:0] PI_Q13 = 17'sd25736;
  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [16:0] ONE_Q14 = 17'sd16384;
  localparam logic [14:0] LOCK_THRESHOLD_RESET = 15'd16383;

  localparam logic signed [CW-1:0] ATAN_TAB [TAB_LEN] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
    34'sd33543515, 34'sd16775850, 34'sd8388437, 34'sd4194282, 34'sd2097149,
    34'sd1048575, 34'sd524287, 34'sd262143, 34'sd131071, 34'sd65535,
    34'sd32767, 34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
    34'sd1023, 34'sd511, 34'sd255, 34'sd127, 34'sd63,
    34'sd31, 34'sd15, 34'sd7, 34'sd3, 34'sd1
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  // Operands of the two matrix angles and the lock data, carried through
  // the square root chain.
  typedef struct packed {
    logic signed [16:0] hx;
    logic signed [16:0] hy;
    logic signed [16:0] bx;
    logic signed [16:0] by;
    logic signed [15:0] cs;
    logic               locked;
    logic signed [14:0] plock;
  } side_t;

  typedef struct packed {
    logic               locked;
    logic signed [14:0] plock;
    logic               h_zero;
    logic               p_zero;
    logic               b_zero;
  } tail_t;

  // Scale by 2^14 and turn the vector into the right half plane.
  function automatic cordic_t prerotate(input logic signed [16:0] x,
                                        input logic signed [16:0] y);
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    cordic_t r;
    xs = {{(CW-31){x[16]}}, x, 14'd0};
    ys = {{(CW-31){y[16]}}, y, 14'd0};
    r.x = xs;
    r.y = ys;
    r.z = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        r.x = ys;
        r.y = -xs;
        r.z = HALF_PI_Q30;
      end else begin
        r.x = -ys;
        r.y = xs;
        r.z = -HALF_PI_Q30;
      end
    end
    return r;
  endfunction

  // Round the Q30 angle half up to Q13 and clamp it to +-lim.
  function automatic logic signed [16:0] round_sat(input logic signed [CW-1:0] z,
                                                  input logic signed [16:0] lim);
    logic signed [CW-1:0] zz;
    logic signed [16:0] q;
    zz = z + CW'(65536);
    q = signed'(zz[CW-1:17]);
    if (q > lim) q = lim;
    else if (q < -lim) q = -lim;
    return q;
  endfunction

endpackage

// ===== rtl/rmea_if.sv =====
// Request and result channel interfaces of the Euler angle converter.
// Depends on nothing but plain logic types.
interface rmea_in_if;
  logic               valid;
  logic               ready;
  logic               direction_mode;
  logic signed [15:0] r1c1;
  logic signed [15:0] r1c2;
  logic signed [15:0] r1c3;
  logic signed [15:0] r2c1;
  logic signed [15:0] r2c2;
  logic signed [15:0] r2c3;
  logic signed [15:0] r3c1;
  logic signed [15:0] r3c2;
  logic signed [15:0] r3c3;
  modport source (output valid, direction_mode, r1c1, r1c2, r1c3, r2c1, r2c2, r2c3,
                  r3c1, r3c2, r3c3, input ready);
  modport sink (input valid, direction_mode, r1c1, r1c2, r1c3, r2c1, r2c2, r2c3,
                r3c1, r3c2, r3c3, output ready);
endinterface

interface rmea_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] heading_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] bank_angle;
  logic               gimbal_locked;
  modport source (output valid, heading_angle, pitch_angle, bank_angle, gimbal_locked,
                  input ready);
  modport sink (input valid, heading_angle, pitch_angle, bank_angle, gimbal_locked,
                output ready);
endinterface

// ===== rtl/rmea_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root (one result bit).
// Depends on rmea_pkg.
module rmea_sqrt_cell
  import rmea_pkg::*;
#(
  parameter int K = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] v_in,
  input  logic [SW-1:0] res_in,
  output logic [SW-1:0] v_out,
  output logic [SW-1:0] res_out
);

  localparam logic [SW-1:0] BIT = SW'(1) << (2 * K);

  logic [SW-1:0] trial;
  logic [SW-1:0] v_next;
  logic [SW-1:0] res_next;

  always_comb begin
    trial = res_in + BIT;
    if (v_in >= trial) begin
      v_next = v_in - trial;
      res_next = (res_in >> 1) + BIT;
    end else begin
      v_next = v_in;
      res_next = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out <= v_next;
      res_out <= res_next;
    end
  end

endmodule

// ===== rtl/rmea_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation, registered.
// Depends on rmea_pkg for the datapath width and the arctangent table.
module rmea_cordic_cell
  import rmea_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic    clk,
  input  logic    en,
  input  cordic_t d_in,
  output cordic_t d_out
);

  cordic_t d_next;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  always_comb begin
    dx = d_in.y >>> IDX;
    dy = d_in.x >>> IDX;
    if (d_in.y > 0) begin
      d_next.x = d_in.x + dx;
      d_next.y = d_in.y - dy;
      d_next.z = d_in.z + ATAN_TAB[IDX];
    end else begin
      d_next.x = d_in.x - dx;
      d_next.y = d_in.y + dy;
      d_next.z = d_in.z - ATAN_TAB[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_out <= d_next;
  end

endmodule

// ===== rtl/rotation_matrix_to_euler_angles_top.sv =====
// Heading, pitch and bank from a rotation matrix: top level pipeline.
// Depends on rmea_pkg, rmea_if, rmea_sqrt_cell and rmea_cordic_cell.
//
// Usage: a matrix request (direction mode plus nine Q1.14 entries) enters
// on the sample channel, the angles leave on the angles channel, both with
// valid/ready. A request is taken whenever ready is high, one per cycle.
// The path is a capture stage, a decode stage (transpose, lock test, lock
// pitch product), 15 square root cells, CORDIC_STAGES CORDIC cells for
// each of the three angles and an output register. The capture stage is
// loaded at the edge that takes the request; throughput is one matrix
// per cycle while the receiver does not stall. When the receiver stalls
// the output register holds and the whole pipeline freezes, which drops
// ready; no data is lost. Reset empties the pipeline and sets
// lock_threshold to 16383. The threshold is written through cfg_wr_en /
// cfg_wr_data; the user must do so only while idle, the block does not enforce it.
module rotation_matrix_to_euler_angles_top
  import rmea_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  rmea_in_if.sink     sample,
  rmea_out_if.source  angles
);

  localparam int L = CORDIC_STAGES + SQRT_CELLS + 3;

  logic [L-1:0] vld;
  logic [14:0]  thr;
  logic         en;

  assign en = !vld[L-1] || angles.ready;
  assign sample.ready = en;
  assign angles.valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      thr <= LOCK_THRESHOLD_RESET;
    end else begin
      if (cfg_wr_en) thr <= cfg_wr_data;
      if (en) vld <= {vld[L-2:0], sample.valid};
    end
  end

  // Capture stage.
  logic               a_mode;
  logic signed [15:0] a_r1c1, a_r1c2, a_r1c3, a_r2c1, a_r2c2, a_r2c3;
  logic signed [15:0] a_r3c1, a_r3c2, a_r3c3;

  always_ff @(posedge clk) begin
    if (en) begin
      a_mode <= sample.direction_mode;
      a_r1c1 <= sample.r1c1;
      a_r1c2 <= sample.r1c2;
      a_r1c3 <= sample.r1c3;
      a_r2c1 <= sample.r2c1;
      a_r2c2 <= sample.r2c2;
      a_r2c3 <= sample.r2c3;
      a_r3c1 <= sample.r3c1;
      a_r3c2 <= sample.r3c2;
      a_r3c3 <= sample.r3c3;
    end
  end

  // Decode stage.
  logic signed [15:0] m12, m13, m31, m32;
  logic signed [16:0] sp;
  logic [16:0]        mag;
  logic signed [15:0] cs_c;
  logic [14:0]        cm;
  logic [28:0]        prod;
  logic signed [14:0] plock_c;
  side_t              side_c;
  logic [28:0]        cs2_c;

  always_comb begin
    m12 = a_mode ? a_r2c1 : a_r1c2;
    m13 = a_mode ? a_r3c1 : a_r1c3;
    m31 = a_mode ? a_r1c3 : a_r3c1;
    m32 = a_mode ? a_r2c3 : a_r3c2;
    sp = -17'(m32);
    mag = sp[16] ? 17'(-sp) : 17'(sp);
    if (sp > ONE_Q14) cs_c = 16'(ONE_Q14);
    else if (sp < -ONE_Q14) cs_c = 16'(-ONE_Q14);
    else cs_c = 16'(sp);
    cm = cs_c[15] ? 15'(-cs_c) : 15'(cs_c);
    prod = 29'(cm) * 29'd12868 + 29'd8192;
    plock_c = cs_c[15] ? -15'(prod[27:14]) : 15'(prod[27:14]);
    cs2_c = 29'(32'(cs_c * cs_c));
    side_c.locked = mag > 17'(thr);
    side_c.plock = plock_c;
    side_c.cs = cs_c;
    side_c.bx = 17'(a_r2c2);
    side_c.by = 17'(m12);
    if (side_c.locked) begin
      side_c.hx = 17'(a_r1c1);
      side_c.hy = -17'(m13);
    end else begin
      side_c.hx = 17'(a_r3c3);
      side_c.hy = 17'(m31);
    end
  end

  side_t       b_side;
  logic [28:0] b_cs2;

  always_ff @(posedge clk) begin
    if (en) begin
      b_side <= side_c;
      b_cs2 <= cs2_c;
    end
  end

  // Square root chain for the pitch cosine.
  logic [SW-1:0] sq_v   [SQRT_CELLS+1];
  logic [SW-1:0] sq_res [SQRT_CELLS+1];
  side_t         sq_side [SQRT_CELLS+1];

  assign sq_v[0] = (SW'(1) << 28) - SW'(b_cs2);
  assign sq_res[0] = '0;
  assign sq_side[0] = b_side;

  genvar j;
  generate
    for (j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
      rmea_sqrt_cell #(.K(SQRT_CELLS - 1 - j)) u_cell (
        .clk     (clk),
        .en      (en),
        .v_in    (sq_v[j]),
        .res_in  (sq_res[j]),
        .v_out   (sq_v[j+1]),
        .res_out (sq_res[j+1])
      );
      always_ff @(posedge clk) begin
        if (en) sq_side[j+1] <= sq_side[j];
      end
    end
  endgenerate

  // CORDIC entry.
  side_t              s_end;
  logic signed [16:0] pc;
  tail_t              tail_c;

  assign s_end = sq_side[SQRT_CELLS];
  assign pc = {2'b00, sq_res[SQRT_CELLS][14:0]};

  always_comb begin
    tail_c.locked = s_end.locked;
    tail_c.plock = s_end.plock;
    tail_c.h_zero = (s_end.hx == 0) && (s_end.hy == 0);
    tail_c.b_zero = (s_end.bx == 0) && (s_end.by == 0);
    tail_c.p_zero = (pc == 0) && (s_end.cs == 0);
  end

  cordic_t hd [CORDIC_STAGES+1];
  cordic_t pd [CORDIC_STAGES+1];
  cordic_t bd [CORDIC_STAGES+1];
  tail_t   tl [CORDIC_STAGES+1];

  assign hd[0] = prerotate(s_end.hx, s_end.hy);
  assign pd[0] = prerotate(pc, 17'(s_end.cs));
  assign bd[0] = prerotate(s_end.bx, s_end.by);
  assign tl[0] = tail_c;

  genvar i;
  generate
    for (i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      rmea_cordic_cell #(.IDX(i)) u_h (.clk(clk), .en(en), .d_in(hd[i]), .d_out(hd[i+1]));
      rmea_cordic_cell #(.IDX(i)) u_p (.clk(clk), .en(en), .d_in(pd[i]), .d_out(pd[i+1]));
      rmea_cordic_cell #(.IDX(i)) u_b (.clk(clk), .en(en), .d_in(bd[i]), .d_out(bd[i+1]));
      always_ff @(posedge clk) begin
        if (en) tl[i+1] <= tl[i];
      end
    end
  endgenerate

  // Output register.
  tail_t              t_end;
  logic signed [16:0] h_q, p_q, b_q;

  assign t_end = tl[CORDIC_STAGES];

  always_comb begin
    h_q = t_end.h_zero ? 17'sd0 : round_sat(hd[CORDIC_STAGES].z, PI_Q13);
    p_q = t_end.p_zero ? 17'sd0 : round_sat(pd[CORDIC_STAGES].z, HALF_PI_Q13);
    b_q = (t_end.b_zero || t_end.locked) ? 17'sd0 : round_sat(bd[CORDIC_STAGES].z, PI_Q13);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angles.heading_angle <= h_q[15:0];
      angles.pitch_angle <= t_end.locked ? t_end.plock : p_q[14:0];
      angles.bank_angle <= b_q[15:0];
      angles.gimbal_locked <= t_end.locked;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the rotation matrix to Euler angle converter.
// Depends on rmea_pkg, rmea_if and rotation_matrix_to_euler_angles_top.
`timescale 1ns / 100ps

typedef struct {
  bit                 dir_mode;
  logic signed [15:0] ent [9];
} matrix_req_t;

typedef struct {
  logic signed [15:0] heading;
  logic signed [14:0] pitch;
  logic signed [15:0] bank;
  logic               locked;
} euler_t;

class euler_scoreboard;
  int              stages;
  logic [14:0]     threshold;
  euler_t          pending[$];
  int              errors;

  function new(int n);
    stages = n;
    threshold = rmea_pkg::LOCK_THRESHOLD_RESET;
    errors = 0;
  endfunction

  function longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function int atan2_fx(int y, int x);
    longint xs, ys, z, t, dx, dy, q;
    z = 0;
    if (x == 0 && y == 0) return 0;
    xs = longint'(x) * 16384;
    ys = longint'(y) * 16384;
    if (xs < 0) begin
      t = xs;
      if (ys >= 0) begin
        xs = ys; ys = -t; z = rmea_pkg::HALF_PI_Q30;
      end else begin
        xs = -ys; ys = t; z = -rmea_pkg::HALF_PI_Q30;
      end
    end
    for (int i = 0; i < stages && i < rmea_pkg::TAB_LEN; i++) begin
      dx = fshift(ys, i);
      dy = fshift(xs, i);
      if (ys > 0) begin
        xs += dx; ys -= dy; z += rmea_pkg::ATAN_TAB[i];
      end else begin
        xs -= dx; ys += dy; z -= rmea_pkg::ATAN_TAB[i];
      end
    end
    q = fshift(z + 65536, 17);
    if (q > 25736) q = 25736;
    if (q < -25736) q = -25736;
    return int'(q);
  endfunction

  function int root_floor(longint v);
    longint res, b;
    res = 0;
    b = longint'(1) << 30;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else res = res >> 1;
      b = b >> 2;
    end
    return int'(res);
  endfunction

  function euler_t angles_of(matrix_req_t m);
    int a [3][3];
    int sp, cs, mag, p, c;
    euler_t e;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        a[r][k] = m.dir_mode ? int'(m.ent[k*3+r]) : int'(m.ent[r*3+k]);
    sp = -a[2][1];
    cs = sp > 16384 ? 16384 : (sp < -16384 ? -16384 : sp);
    mag = sp < 0 ? -sp : sp;
    e.locked = mag > int'(threshold);
    if (e.locked) begin
      p = int'((longint'(cs < 0 ? -cs : cs) * 12868 + 8192) >>> 14);
      e.pitch = 15'(cs < 0 ? -p : p);
      e.heading = 16'(atan2_fx(-a[0][2], a[0][0]));
      e.bank = '0;
    end else begin
      c = root_floor(longint'(268435456) - longint'(cs) * cs);
      p = atan2_fx(cs, c);
      if (p > 12868) p = 12868;
      if (p < -12868) p = -12868;
      e.pitch = 15'(p);
      e.heading = 16'(atan2_fx(a[2][0], a[2][2]));
      e.bank = 16'(atan2_fx(a[0][1], a[1][1]));
    end
    return e;
  endfunction

  function void note_request(matrix_req_t m);
    pending.push_back(angles_of(m));
  endfunction

  function void check_result(euler_t got);
    euler_t exp_e;
    if (pending.size() == 0) begin
      $error("angles result with no request outstanding");
      errors++;
      return;
    end
    exp_e = pending.pop_front();
    if (got.heading !== exp_e.heading) begin
      $error("heading_angle expected %0d actual %0d", exp_e.heading, got.heading);
      errors++;
    end
    if (got.pitch !== exp_e.pitch) begin
      $error("pitch_angle expected %0d actual %0d", exp_e.pitch, got.pitch);
      errors++;
    end
    if (got.bank !== exp_e.bank) begin
      $error("bank_angle expected %0d actual %0d", exp_e.bank, got.bank);
      errors++;
    end
    if (got.locked !== exp_e.locked) begin
      $error("gimbal_locked expected %0d actual %0d", exp_e.locked, got.locked);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import rmea_pkg::*;

  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 18;
  localparam int IDLE_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [14:0] cfg_wr_data = '0;
  bit          hold_req = 1'b0;
  int          idle_cycles = 0;

  rmea_in_if  sample ();
  rmea_out_if angles ();

  euler_scoreboard angle_board = new(STAGES);

  rotation_matrix_to_euler_angles_top #(.CORDIC_STAGES(STAGES)) DUT (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .sample(sample.sink), .angles(angles.source)
  );

  always #5 clk = ~clk;

  initial begin
    sample.valid = 1'b0;
    sample.direction_mode = 1'b0;
    {sample.r1c1, sample.r1c2, sample.r1c3} = '0;
    {sample.r2c1, sample.r2c2, sample.r2c3} = '0;
    {sample.r3c1, sample.r3c2, sample.r3c3} = '0;
    angles.ready = 1'b0;
  end

  // Receiver: random stalls, runs of full readiness, and one long hold.
  initial begin
    int hold_left, mode_left;
    bit busy_mode;
    hold_left = 0;
    mode_left = 0;
    busy_mode = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(5, 60);
        busy_mode = $urandom_range(0, 1);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        angles.ready <= 1'b0;
      end else if (busy_mode) angles.ready <= 1'b1;
      else angles.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    euler_t got;
    if (!rst && angles.valid && angles.ready) begin
      got.heading = angles.heading_angle;
      got.pitch = angles.pitch_angle;
      got.bank = angles.bank_angle;
      got.locked = angles.gimbal_locked;
      angle_board.check_result(got);
    end
  end

  // Watchdog on cycles with no request or result taken.
  always @(posedge clk) begin
    if ((sample.valid && sample.ready) || (angles.valid && angles.ready) || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic send_matrix(matrix_req_t m);
    @(negedge clk);
    sample.direction_mode <= m.dir_mode;
    sample.r1c1 <= m.ent[0]; sample.r1c2 <= m.ent[1]; sample.r1c3 <= m.ent[2];
    sample.r2c1 <= m.ent[3]; sample.r2c2 <= m.ent[4]; sample.r2c3 <= m.ent[5];
    sample.r3c1 <= m.ent[6]; sample.r3c2 <= m.ent[7]; sample.r3c3 <= m.ent[8];
    sample.valid <= 1'b1;
    do @(posedge clk); while (!sample.ready);
    angle_board.note_request(m);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    sample.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain;
    pause_sender(1);
    while (angle_board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [14:0] v);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    angle_board.threshold = v;
  endtask

  function automatic logic signed [15:0] q14(real v);
    return 16'($rtoi(v * 16384.0 + (v >= 0.0 ? 0.5 : -0.5)));
  endfunction

  function automatic real rand_angle(real span);
    return (real'($urandom_range(0, 200000)) / 100000.0 - 1.0) * span;
  endfunction

  // Heading-pitch-bank rotation with random angles; sometimes near lock.
  function automatic matrix_req_t rotation_req();
    matrix_req_t m;
    real h, p, b, ch, sh, cp, s_p, cb, sb;
    h = rand_angle(3.14159265);
    b = rand_angle(3.14159265);
    if ($urandom_range(0, 4) == 0) p = (($urandom_range(0, 1) != 0) ? 1.0 : -1.0)
                                      * (1.5707963 - rand_angle(0.02) * rand_angle(1.0));
    else p = rand_angle(1.5707963);
    ch = $cos(h); sh = $sin(h); cp = $cos(p); s_p = $sin(p); cb = $cos(b); sb = $sin(b);
    m.dir_mode = $urandom_range(0, 1);
    m.ent[0] = q14(ch * cb + sh * s_p * sb);
    m.ent[1] = q14(sb * cp);
    m.ent[2] = q14(-sh * cb + ch * s_p * sb);
    m.ent[3] = q14(-ch * sb + sh * s_p * cb);
    m.ent[4] = q14(cb * cp);
    m.ent[5] = q14(sb * sh + ch * s_p * cb);
    m.ent[6] = q14(sh * cp);
    m.ent[7] = q14(-s_p);
    m.ent[8] = q14(ch * cp);
    if (m.dir_mode) begin
      // Keep the pitch sine entry where the transposed read finds it.
      logic signed [15:0] t;
      t = m.ent[5]; m.ent[5] = m.ent[7]; m.ent[7] = t;
    end
    return m;
  endfunction

  function automatic matrix_req_t noise_req();
    matrix_req_t m;
    m.dir_mode = $urandom_range(0, 1);
    for (int i = 0; i < 9; i++)
      m.ent[i] = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(0, 32768) - 16384);
    return m;
  endfunction

  function automatic matrix_req_t fixed_req(bit md, logic signed [15:0] v,
                                            logic signed [15:0] sine_entry);
    matrix_req_t m;
    m.dir_mode = md;
    for (int i = 0; i < 9; i++) m.ent[i] = v;
    m.ent[md ? 5 : 7] = sine_entry;
    return m;
  endfunction

  task automatic random_phase(int count, bit with_hold);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 3) hold_req = 1'b1;
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 12));
      end
      burst--;
      send_matrix(($urandom_range(0, 4) == 0) ? noise_req() : rotation_req());
    end
  endtask

  initial begin
    matrix_req_t m;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: identity, lock both signs, out-of-range sine, zero vectors.
    for (int md = 0; md < 2; md++) begin
      m = fixed_req(1'(md), 0, 0);
      m.ent[0] = 16384; m.ent[4] = 16384; m.ent[8] = 16384;
      send_matrix(m);
      send_matrix(fixed_req(1'(md), 0, 16'sh4000));
      send_matrix(fixed_req(1'(md), 0, -16'sh4000));
      send_matrix(fixed_req(1'(md), 0, 16'sh8000));
      send_matrix(fixed_req(1'(md), 0, 16'sh7FFF));
      send_matrix(fixed_req(1'(md), -16384, -16383));
      send_matrix(fixed_req(1'(md), 16384, 16383));
      send_matrix(fixed_req(1'(md), 16'sh7FFF, 0));
      send_matrix(fixed_req(1'(md), 16'sh8000, 16'sh8000));
      send_matrix(fixed_req(1'(md), -1, 1));
    end
    random_phase(130, 1'b0);

    write_threshold(15'd0);
    send_matrix(fixed_req(0, 0, 0));
    send_matrix(fixed_req(1, 100, 1));
    random_phase(130, 1'b1);

    write_threshold(15'd16384);
    send_matrix(fixed_req(0, 5, 16'sh8000));
    random_phase(130, 1'b0);

    write_threshold(15'($urandom_range(12000, 16380)));
    random_phase(130, 1'b0);

    write_threshold(15'd16383);
    random_phase(110, 1'b0);

    drain();
    if (angle_board.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
